### hdl/histogram_mode_finder_top_defines.svh
// Assertion macros used by the port checker of the mode finder.
`ifndef HISTOGRAM_MODE_FINDER_TOP_DEFINES_SVH
`define HISTOGRAM_MODE_FINDER_TOP_DEFINES_SVH

// Plain clocked assertion, evaluated at every edge, reset included.
`define HMF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Clocked assertion that is switched off while reset is applied.
`define HMF_ASSERT_RUN(label, prop, msg) \
  `HMF_ASSERT(label, disable iff (!rst_n) prop, msg)

`endif

### hdl/hmf_pkg.sv
`default_nettype none

package hmf_pkg;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_FETCH = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0] opcode;
    logic [6:0] sample_value;
  } hmf_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [6:0]  mode_value;
    logic [15:0] mode_count;
    logic        found;
  } hmf_out_t;

endpackage

`default_nettype wire

### hdl/hmf_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module hmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/hmf_ctrl.sv
`default_nettype none

// Sequencer: clearing sweep, add read-modify-write and the mode scan.
module hmf_ctrl import hmf_pkg::*; #(
  parameter int VALUE_BINS = 128,
  parameter int COUNT_BITS = 16,
  localparam int IDX_W = $clog2(VALUE_BINS)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire hmf_in_t               in_data,
  output logic                       ram_we,
  output logic      [IDX_W-1:0]      ram_waddr,
  output logic      [COUNT_BITS-1:0] ram_wdata,
  output logic      [IDX_W-1:0]      ram_raddr,
  input  wire logic [COUNT_BITS-1:0] ram_rdata,
  output logic                       res_push,
  output hmf_out_t                   res_data,
  input  wire logic                  slot_free
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_POST
  } state_t;

  localparam logic [IDX_W:0]   BINS_L   = (IDX_W + 1)'(VALUE_BINS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VALUE_BINS - 1);

  state_t                state_r, state_nxt;
  logic [IDX_W-1:0]      clr_r, clr_nxt;
  logic [IDX_W-1:0]      add_addr_r, add_addr_nxt;
  logic [IDX_W:0]        scan_r, scan_nxt;
  logic [COUNT_BITS-1:0] max_r, max_nxt;
  hmf_out_t              res_r, res_nxt;

  logic                  accept;
  logic                  in_range;
  logic [IDX_W-1:0]      sample_addr;
  logic [IDX_W:0]        scan_inc;
  logic [COUNT_BITS-1:0] bin_inc;
  hmf_out_t              miss;

  assign in_ready    = (state_r == ST_IDLE);
  assign accept      = in_valid && in_ready;
  assign in_range    = 32'(in_data.sample_value) < 32'(VALUE_BINS);
  assign sample_addr = IDX_W'(in_data.sample_value);
  assign scan_inc    = scan_r + (IDX_W + 1)'(1);
  assign bin_inc     = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_BITS'(1);
  assign miss        = '{mode_value: 7'd0, mode_count: 16'd0, found: 1'b0};

  assign res_data = res_r;
  assign res_push = (state_r == ST_POST) && slot_free;

  // While scanning, the read one bin ahead is issued so a bin is checked each cycle.
  always_comb begin
    if (state_r == ST_SCAN) begin
      ram_raddr = scan_inc[IDX_W-1:0];
    end else if (in_data.opcode == OP_FETCH) begin
      ram_raddr = scan_r[IDX_W-1:0];
    end else begin
      ram_raddr = sample_addr;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    add_addr_nxt = add_addr_r;
    scan_nxt     = scan_r;
    max_nxt      = max_r;
    res_nxt      = res_r;
    ram_we       = 1'b0;
    ram_waddr    = clr_r;
    ram_wdata    = '0;
    case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + IDX_W'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_data.opcode)
            OP_ADD: begin
              scan_nxt = '0;
              if (in_range) begin
                add_addr_nxt = sample_addr;
                state_nxt    = ST_ADD;
              end
            end
            OP_FETCH: begin
              if (max_r == '0) begin
                scan_nxt  = BINS_L;
                res_nxt   = miss;
                state_nxt = ST_POST;
              end else if (scan_r == BINS_L) begin
                res_nxt   = miss;
                state_nxt = ST_POST;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            OP_CLEAR: begin
              clr_nxt   = '0;
              max_nxt   = '0;
              scan_nxt  = '0;
              state_nxt = ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADD: begin
        ram_we    = 1'b1;
        ram_waddr = add_addr_r;
        ram_wdata = bin_inc;
        if (bin_inc > max_r) begin
          max_nxt = bin_inc;
        end
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        scan_nxt = scan_inc;
        if (ram_rdata == max_r) begin
          res_nxt   = '{mode_value: 7'(scan_r), mode_count: 16'(max_r), found: 1'b1};
          state_nxt = ST_POST;
        end else if (scan_inc == BINS_L) begin
          res_nxt   = miss;
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      scan_r  <= '0;
      max_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      scan_r  <= scan_nxt;
      max_r   <= max_nxt;
    end
    add_addr_r <= add_addr_nxt;
    res_r      <= res_nxt;
  end

endmodule

`default_nettype wire

### hdl/hmf_out_stage.sv
`default_nettype none

// Result register: holds one transaction until the consumer takes it.
module hmf_out_stage import hmf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire hmf_out_t push_data,
  output logic          slot_free,
  output logic          out_valid,
  input  wire logic     out_ready,
  output hmf_out_t      out_data
);

  logic     out_valid_r;
  hmf_out_t out_data_r;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (push) begin
      out_data_r <= push_data;
    end
  end

endmodule

`default_nettype wire

### hdl/histogram_mode_finder_top.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    hmf_in_t  (opcode, sample_value)
// out_      output     out_valid / out_ready  hmf_out_t (mode_value, mode_count, found)
//
// An add reads the bin from the histogram RAM, then writes the incremented
// count back through its single write port.
// A fetch examines bins from the current scan position; the scan checks one
// bin per cycle, limited by the one read port of the RAM.
// A clear zeroes one RAM entry per cycle.
// After reset a clearing pass over all VALUE_BINS entries runs with in_ready low.
// A result waiting in the output register does not stall input; a later fetch
// holds its result until the register is free.

// Mode finder over a histogram of sample values.
// The bin counts live in one RAM. Add transactions are a read-modify-write of
// one bin, and the running maximum count is kept in a register. Because only
// one transaction is in flight at a time, a read never overlaps a write to
// the same bin, so no forwarding is needed. The fetch scan reads one bin ahead
// of the bin being compared so that each cycle retires one bin.
module histogram_mode_finder_top import hmf_pkg::*; #(
  parameter int VALUE_BINS = 128,
  parameter int COUNT_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire hmf_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output hmf_out_t      out_data
);

  localparam int IDX_W = $clog2(VALUE_BINS);

  // Histogram RAM ports.
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;

  // Hand-off from the sequencer to the output register.
  logic     res_push;
  hmf_out_t res_data;
  logic     slot_free;

  hmf_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (VALUE_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The sequencer owns the maximum count and the scan position; it also runs
  // the clearing sweep after reset and for every clear transaction.
  hmf_ctrl #(
    .VALUE_BINS (VALUE_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_push  (res_push),
    .res_data  (res_data),
    .slot_free (slot_free)
  );

  // Output register decouples the consumer from the sequencer.
  hmf_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### hdl/hmf_checker.sv
`default_nettype none

`include "histogram_mode_finder_top_defines.svh"

// Port-level checks on the mode finder.
module hmf_port_checker import hmf_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire hmf_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire hmf_out_t out_data
);

  // A stalled result transaction stays put.
  `HMF_ASSERT_RUN(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)), "result changed while stalled")

  // A not-found result carries zero value and count.
  `HMF_ASSERT_RUN(a_miss_zero, (out_valid && !out_data.found) |-> (out_data.mode_value == 7'd0 && out_data.mode_count == 16'd0), "not-found result with nonzero payload")

  // A new result appears only when input was blocked just before it.
  `HMF_ASSERT_RUN(a_rose_busy, $rose(out_valid) |-> !$past(in_ready), "result appeared without a busy cycle")

  // Fetch and clear transactions both keep the input blocked the next cycle.
  `HMF_ASSERT_RUN(a_busy_after, (in_valid && in_ready && (in_data.opcode == OP_FETCH || in_data.opcode == OP_CLEAR)) |=> !in_ready, "input ready right after fetch or clear")

  // Reset starts the clearing pass, so input is blocked right after it.
  `HMF_ASSERT(a_reset_clear, !rst_n |=> !in_ready, "input ready right after reset")

endmodule

bind histogram_mode_finder_top hmf_port_checker u_chk (.*);

`default_nettype wire

### sim/hmf_checker.sv
`default_nettype none

// Watches both channels of the mode finder, keeps its own histogram, and
// compares every result transaction with the oldest predicted mode.
module hmf_checker import hmf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_ready,
  input  wire hmf_in_t  in_data,
  input  wire logic     out_valid,
  input  wire logic     out_ready,
  input  wire hmf_out_t out_data,
  output int            error_count,
  output int            pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NUM_BINS      = 128;
  localparam logic [15:0] COUNT_CEILING = 16'hFFFF;

  logic [15:0] bin_count [NUM_BINS];
  logic [15:0] peak_count;
  logic [7:0]  scan_pos;
  hmf_out_t    expected_modes [$];
  int          mismatches = 0;

  task automatic empty_histogram();
    foreach (bin_count[i]) bin_count[i] = '0;
    peak_count = '0;
    scan_pos   = '0;
  endtask

  task automatic track_transaction(input hmf_in_t t);
    hmf_out_t   mode;
    logic [7:0] pos;
    bit         hit;
    mode = '0;
    hit  = 1'b0;
    case (t.opcode)
      OP_ADD: begin
        scan_pos = '0;
        if (bin_count[t.sample_value] != COUNT_CEILING) begin
          bin_count[t.sample_value] = bin_count[t.sample_value] + 16'd1;
        end
        if (bin_count[t.sample_value] > peak_count) begin
          peak_count = bin_count[t.sample_value];
        end
      end
      OP_CLEAR: begin
        empty_histogram();
      end
      OP_FETCH: begin
        // An empty histogram parks the scan at the end, like an exhausted scan.
        if (peak_count == '0) begin
          scan_pos = 8'(NUM_BINS);
        end else begin
          while (scan_pos < NUM_BINS && !hit) begin
            pos      = scan_pos;
            scan_pos = scan_pos + 8'd1;
            if (bin_count[pos[6:0]] == peak_count) begin
              mode.mode_value = pos[6:0];
              mode.mode_count = peak_count;
              mode.found      = 1'b1;
              hit             = 1'b1;
            end
          end
        end
        expected_modes = {expected_modes, mode};
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_mode(input hmf_out_t got);
    hmf_out_t want;
    if (expected_modes.size() == 0) begin
      mismatches++;
      $display("%0t: result with nothing expected: value=%0d count=%0d found=%0b",
               $time, got.mode_value, got.mode_count, got.found);
    end else begin
      want = expected_modes.pop_front();
      if (got.mode_value !== want.mode_value) begin
        mismatches++;
        $display("%0t: mode_value expected %0d, actual %0d",
                 $time, want.mode_value, got.mode_value);
      end
      if (got.mode_count !== want.mode_count) begin
        mismatches++;
        $display("%0t: mode_count expected %0d, actual %0d",
                 $time, want.mode_count, got.mode_count);
      end
      if (got.found !== want.found) begin
        mismatches++;
        $display("%0t: found expected %0b, actual %0b", $time, want.found, got.found);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      empty_histogram();
      expected_modes.delete();
    end else begin
      // The result leaving now belongs to an earlier fetch, so compare first.
      if (out_valid && out_ready) check_mode(out_data);
      if (in_valid && in_ready) track_transaction(in_data);
    end
    error_count   <= mismatches;
    pending_count <= expected_modes.size();
  end

endmodule

`default_nettype wire

### sim/tb_top.sv
`default_nettype none

// Top of the mode finder testbench. It only creates stimulus and gives the
// verdict; the checker beside the block does all prediction and comparison.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hmf_pkg::*;

  // The package names the three real operations; the fourth code does nothing.
  localparam logic [1:0] OP_UNUSED      = 2'd3;
  // Length of the long receiver hold-off that backs the block up.
  localparam int         HOLD_CYCLES    = 300;
  // Drain time, long enough to cover a clear or a full fetch scan.
  localparam int         DRAIN_CYCLES   = 200;
  localparam int         RANDOM_PER_PHASE = 120;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  hmf_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  hmf_out_t out_data;

  // Idle and stall rates in percent, changed by the stimulus between phases.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_request  = 1'b0;
  int sent_items    = 0;
  int error_count;
  int pending_count;

  int idle_plan  [4] = '{0, 76, 0, 9};
  int stall_plan [4] = '{0, 0, 76, 9};

  always #6 clk = ~clk;

  histogram_mode_finder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  hmf_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  // Result side. Each cycle the receiver decides on out_ready from the current
  // stall rate. When a hold-off is requested it drops out_ready and counts the
  // cycles itself, independent of what the sender is doing.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offers one input transaction and returns at the edge where it is taken.
  // Idle cycles go before the offer, with junk on the data lines, so that a
  // valid that stays high is never lowered and raised within one step.
  task automatic offer(input logic [1:0] op, input logic [6:0] value);
    hmf_in_t item;
    hmf_in_t junk;
    item.opcode       = op;
    item.sample_value = value;
    while ($urandom_range(99) < send_idle_pct) begin
      junk.opcode       = 2'($urandom_range(3));
      junk.sample_value = 7'($urandom_range(127));
      in_valid <= 1'b0;
      in_data  <= junk;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    if (op != OP_UNUSED) sent_items++;
  endtask

  // Waits until the checker has no expected result outstanding. Valid drops
  // first so the last transaction is not taken again. The checker registers the
  // count after each edge, so the value seen here lags its own queue.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // Random data sets. Most of the traffic is a well-formed sequence: maybe a
  // clear, a burst of adds from a narrow or wide value pool, then a run of
  // fetches that walks the modes. Unused opcodes are sprinkled in as noise,
  // and an occasional add inside the fetch run restarts the scan early.
  task automatic run_random(input int quota);
    int start;
    int pool;
    int n;
    start = sent_items;
    while (sent_items - start < quota) begin
      if ($urandom_range(3) == 0) offer(OP_CLEAR, 7'($urandom_range(127)));
      case ($urandom_range(2))
        0: pool = 3;
        1: pool = 15;
        default: pool = 127;
      endcase
      n = $urandom_range(12, 1);
      repeat (n) begin
        if ($urandom_range(99) < 8) begin
          offer(OP_UNUSED, 7'($urandom_range(127)));
        end else begin
          offer(OP_ADD, 7'($urandom_range(pool)));
        end
      end
      n = $urandom_range(6, 1);
      repeat (n) begin
        if ($urandom_range(99) < 10) begin
          offer(OP_ADD, 7'($urandom_range(pool)));
        end else begin
          offer(OP_FETCH, 7'($urandom_range(127)));
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, no idling. It opens on an empty histogram, checks that an
    // exhausted scan keeps reporting not found, that an add restarts the scan,
    // that the unused opcode changes nothing, and that a clear empties
    // everything. Values 0, 127, 85 and 42 toggle every sample bit.
    offer(OP_FETCH, 7'd127);
    offer(OP_FETCH, 7'd0);
    offer(OP_ADD,   7'd0);
    offer(OP_ADD,   7'd127);
    offer(OP_ADD,   7'd127);
    offer(OP_FETCH, 7'd0);
    offer(OP_FETCH, 7'd0);
    offer(OP_ADD,   7'd0);
    offer(OP_FETCH, 7'd0);
    offer(OP_FETCH, 7'd0);
    offer(OP_FETCH, 7'd0);
    offer(OP_UNUSED, 7'd127);
    offer(OP_FETCH, 7'd0);
    offer(OP_ADD,   7'd85);
    offer(OP_ADD,   7'd42);
    offer(OP_FETCH, 7'd0);
    offer(OP_CLEAR, 7'd0);
    offer(OP_FETCH, 7'd0);
    offer(OP_FETCH, 7'd0);
    offer(OP_ADD,   7'd127);
    offer(OP_FETCH, 7'd0);
    offer(OP_FETCH, 7'd0);
    offer(OP_CLEAR, 7'd127);
    wait_drained();

    // Back-pressure. Ten values with one count each give ten modes. The
    // receiver then holds off for a long stretch while fetches keep coming,
    // so the output register fills and the block has to stall its input.
    // Afterwards the sender waits until every result has arrived.
    offer(OP_CLEAR, 7'd0);
    for (int v = 1; v <= 10; v++) offer(OP_ADD, 7'(v));
    hold_request = 1'b1;
    repeat (14) offer(OP_FETCH, 7'($urandom_range(127)));
    wait_drained();

    // Random part, one phase per idling pattern.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_plan[p];
      stall_pct     = stall_plan[p];
      run_random(RANDOM_PER_PHASE);
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #30_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
